FILE: hw/rtl/ipv4_dotted_quad_checker_defines.svh
// Assertion macros for the dotted-quad checker.
`ifndef IPV4_DOTTED_QUAD_CHECKER_DEFINES_SVH
`define IPV4_DOTTED_QUAD_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define CHK_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

`define CHK_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define CHK_IMPLY(name, clk, rst, ante, cons)

`define CHK_NEVER(name, clk, rst, expr)

`endif

`endif

FILE: hw/rtl/ipv4dq_pkg.sv
// Shared types and constants of the dotted-quad checker.
package ipv4dq_pkg;

   localparam int PART_COUNT = 4;
   localparam int PART_IDX_W = $clog2(PART_COUNT);
   localparam logic [PART_IDX_W-1:0] PART_LAST = PART_IDX_W'(PART_COUNT - 1);

   localparam int VALUE_W = 9;
   localparam int PROD_W  = 12;
   localparam logic [VALUE_W-1:0] VALUE_SAT = 9'd256;
   localparam logic [PROD_W-1:0]  PROD_SAT  = 12'd256;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_STRICT_MODE       = 2'd0;
   localparam logic [1:0] REG_ALLOW_PADDING     = 2'd1;
   localparam logic [1:0] REG_ALLOW_EMPTY_PARTS = 2'd2;
   localparam logic [1:0] REG_PAD_CHAR          = 2'd3;

   typedef struct packed {
      logic       strict_mode;
      logic       allow_padding;
      logic       allow_empty_parts;
      logic [7:0] pad_char;
   } cfg_type;

   typedef enum logic [2:0] {
      CLS_DIGIT,
      CLS_DOT,
      CLS_PAD,
      CLS_OTHER,
      CLS_END
   } cls_type;

   typedef struct packed {
      cls_type    cls;
      logic [3:0] digit;
   } item_type;

   typedef struct packed {
      logic                   full;
      logic [QUEUE_CNT_W-1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic               pop_end;
      logic [VALUE_W-1:0] part_value;
   } back_status_type;

   typedef enum logic [2:0] {
      PH_BEFORE = 3'b001,
      PH_DIGITS = 3'b010,
      PH_AFTER  = 3'b100
   } phase_type;

endpackage

FILE: hw/rtl/ipv4_dotted_quad_checker.sv
// Dotted-quad address checker: top level with the register block.
//
// The checker takes a string one byte per request, then an end request, and
// answers each end request with one response saying whether the string was four
// dot-separated decimal parts. One request is taken per clock cycle when the
// response side keeps up; a byte reaches the parse logic through a two-entry
// queue, and the response register loads in the same cycle as the end request
// leaves the queue, so a verdict passes through the queue and then the response
// register, and is held back while an earlier response is still being held up.
// The queue fills, and the request side stalls, only while a response is held
// up by the response side. Configuration registers (strict mode, padding, empty
// parts, pad byte) sit at byte offsets 0, 4, 8 and 12 and should be changed
// only between strings with the block idle.
`include "ipv4_dotted_quad_checker_defines.svh"

module ipv4_dotted_quad_checker import ipv4dq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [7:0]            req_char_code,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_valid_res,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type          cfg_ff, cfg_in;
   logic [1:0]       reg_idx;
   logic             csr_write;

   logic             push;
   item_type         push_item;
   logic             q_valid;
   item_type         q_item;
   logic             pop;
   queue_status_type q_status;
   back_status_type  b_status;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_idx)
            REG_STRICT_MODE:       cfg_in.strict_mode       = csr_pwdata[0];
            REG_ALLOW_PADDING:     cfg_in.allow_padding     = csr_pwdata[0];
            REG_ALLOW_EMPTY_PARTS: cfg_in.allow_empty_parts = csr_pwdata[0];
            REG_PAD_CHAR:          cfg_in.pad_char          = csr_pwdata[7:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_STRICT_MODE:       csr_prdata = {31'd0, cfg_ff.strict_mode};
         REG_ALLOW_PADDING:     csr_prdata = {31'd0, cfg_ff.allow_padding};
         REG_ALLOW_EMPTY_PARTS: csr_prdata = {31'd0, cfg_ff.allow_empty_parts};
         REG_PAD_CHAR:          csr_prdata = {24'd0, cfg_ff.pad_char};
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strict_mode       <= 1'b0;
         cfg_ff.allow_padding     <= 1'b0;
         cfg_ff.allow_empty_parts <= 1'b0;
         cfg_ff.pad_char          <= CHAR_SPACE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ipv4dq_front u_front (
      .req_valid     (req_valid),
      .req_action    (req_action),
      .req_char_code (req_char_code),
      .cfg           (cfg_ff),
      .queue_full    (q_status.full),
      .req_stall     (req_stall),
      .push          (push),
      .push_item     (push_item)
   );

   ipv4dq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .out_valid (q_valid),
      .out_item  (q_item),
      .status    (q_status)
   );

   ipv4dq_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (q_valid),
      .in_item       (q_item),
      .pop           (pop),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_valid_res (rsp_valid_res),
      .status        (b_status)
   );

   // A new response must come from an end request leaving the queue.
   `CHK_IMPLY(a_rsp_from_end, clock, reset, $rose(rsp_valid), $past(b_status.pop_end))
   // The request side stalls only when every queue entry is taken.
   `CHK_IMPLY(a_stall_when_full, clock, reset, req_stall, q_status.count == QUEUE_CNT_W'(QUEUE_DEPTH))
   // The running part value never climbs past its saturation point.
   `CHK_NEVER(a_value_saturates, clock, reset, b_status.part_value > VALUE_SAT)

endmodule

FILE: hw/rtl/ipv4dq_front.sv
// Front end: classifies each request byte and pushes it into the queue.
module ipv4dq_front import ipv4dq_pkg::*; (
   input  logic       req_valid,
   input  logic       req_action,
   input  logic [7:0] req_char_code,
   input  cfg_type    cfg,
   input  logic       queue_full,
   output logic       req_stall,
   output logic       push,
   output item_type   push_item
);

   logic is_digit;
   logic is_space;
   logic is_pad;
   logic [7:0] digit_full;

   always_comb begin
      is_digit = (req_char_code >= CHAR_ZERO) && (req_char_code <= CHAR_NINE);
      is_space = (req_char_code == CHAR_SPACE) ||
                 ((req_char_code >= CHAR_TAB) && (req_char_code <= CHAR_CR));
      // With padding allowed, strict mode pads with whitespace and ignores the pad byte.
      if (!cfg.allow_padding) begin
         is_pad = 1'b0;
      end else if (cfg.strict_mode || (cfg.pad_char == CHAR_SPACE)) begin
         is_pad = is_space;
      end else begin
         is_pad = (req_char_code == cfg.pad_char);
      end
      digit_full = req_char_code - CHAR_ZERO;

      push_item.digit = digit_full[3:0];
      if (req_action) begin
         push_item.cls = CLS_END;
      end else if (is_digit) begin
         push_item.cls = CLS_DIGIT;
      end else if (req_char_code == CHAR_DOT) begin
         push_item.cls = CLS_DOT;
      end else if (is_pad) begin
         push_item.cls = CLS_PAD;
      end else begin
         push_item.cls = CLS_OTHER;
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

endmodule

FILE: hw/rtl/ipv4dq_queue.sv
// Short queue of classified requests between the front and back ends.
module ipv4dq_queue import ipv4dq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output logic             out_valid,
   output item_type         out_item,
   output queue_status_type status
);

   item_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign out_valid    = (count_ff != '0);
   assign out_item     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.count = count_ff;

endmodule

FILE: hw/rtl/ipv4dq_back.sv
// Back end: runs the per-string parse and holds the response register.
module ipv4dq_back import ipv4dq_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            in_valid,
   input  item_type        in_item,
   output logic            pop,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output logic            rsp_valid_res,
   output back_status_type status
);

   phase_type              phase_ff, phase_in;
   logic [PART_IDX_W-1:0]  part_idx_ff, part_idx_in;
   logic [VALUE_W-1:0]     part_value_ff, part_value_in;
   logic                   digit_seen_ff, digit_seen_in;
   logic                   failed_ff, failed_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_res_ff, rsp_res_in;

   logic                   is_end;
   logic                   part_ok;
   logic [PROD_W-1:0]      value_ext;
   logic [PROD_W-1:0]      prod;

   always_comb begin
      is_end = (in_item.cls == CLS_END);
      // An end request needs the response register free or being drained.
      pop = in_valid && (!is_end || !rsp_valid_ff || !rsp_stall);

      if (cfg.strict_mode) begin
         part_ok = digit_seen_ff;
      end else begin
         part_ok = (digit_seen_ff || cfg.allow_empty_parts) && !part_value_ff[VALUE_W-1];
      end

      value_ext = {{(PROD_W - VALUE_W){1'b0}}, part_value_ff};
      prod      = (value_ext << 3) + (value_ext << 1) + {{(PROD_W - 4){1'b0}}, in_item.digit};

      phase_in      = phase_ff;
      part_idx_in   = part_idx_ff;
      part_value_in = part_value_ff;
      digit_seen_in = digit_seen_ff;
      failed_in     = failed_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (pop) begin
         if (is_end) begin
            rsp_valid_in  = 1'b1;
            rsp_res_in    = !failed_ff && (part_idx_ff == PART_LAST) && part_ok;
            phase_in      = PH_BEFORE;
            part_idx_in   = '0;
            part_value_in = '0;
            digit_seen_in = 1'b0;
            failed_in     = 1'b0;
         end else if (!failed_ff) begin
            unique case (in_item.cls)
               CLS_DIGIT: begin
                  if (phase_ff == PH_AFTER) begin
                     failed_in = 1'b1;
                  end else begin
                     part_value_in = (prod > PROD_SAT) ? VALUE_SAT : prod[VALUE_W-1:0];
                     phase_in      = PH_DIGITS;
                     digit_seen_in = 1'b1;
                  end
               end
               CLS_DOT: begin
                  if ((part_idx_ff == PART_LAST) || !part_ok) begin
                     failed_in = 1'b1;
                  end else begin
                     part_idx_in   = part_idx_ff + 1'b1;
                     phase_in      = PH_BEFORE;
                     part_value_in = '0;
                     digit_seen_in = 1'b0;
                  end
               end
               CLS_PAD: begin
                  if (phase_ff == PH_DIGITS) begin
                     phase_in = PH_AFTER;
                  end
               end
               default: begin
                  failed_in = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_BEFORE;
         part_idx_ff   <= '0;
         part_value_ff <= '0;
         digit_seen_ff <= 1'b0;
         failed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         part_idx_ff   <= part_idx_in;
         part_value_ff <= part_value_in;
         digit_seen_ff <= digit_seen_in;
         failed_ff     <= failed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_valid_res     = rsp_res_ff;
   assign status.pop_end    = pop && is_end;
   assign status.part_value = part_value_ff;

endmodule
